// ===== src/calendar_date_counter_defines.svh =====
// Assertion macros shared by the calendar date counter modules
`ifndef CALENDAR_DATE_COUNTER_DEFINES_SVH
`define CALENDAR_DATE_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define CALDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition is followed in the next cycle by another
`define CALDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define CALDC_ASSERT(lbl, prop, msg)
`define CALDC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== src/caldc_pkg.sv =====
// Types, codes and calendar helper functions of the calendar date counter
package caldc_pkg;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_NEXT = 3'd1,
    OP_PREV = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_CLAMP    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_YEAR  = 2'd1,
    S_MONTH = 2'd2
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;
    logic year_step;
    logic month_init;
    logic month_step;
    logic commit;
    logic finish;
  } caldc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic quick;
    logic year_done;
    logic month_done;
  } caldc_sts_t;

  localparam logic [8:0] DaysCommon = 9'd365;
  localparam logic [2:0] WdayFirst  = 3'd1;  // first day of the start year is a Monday
  localparam logic [3:0] MonthLast  = 4'd12;

  // Leap year from the low year bits and the year modulo 100 and 400
  function automatic logic is_leap(logic [1:0] y_lo, logic [6:0] c100, logic [8:0] c400);
    return (c400 == 9'd0) || ((y_lo == 2'd0) && (c100 != 7'd0));
  endfunction

  // Length of a month, zero for a month code that means nothing
  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Reduce a small value modulo 7 by conditional subtraction
  function automatic logic [2:0] mod7(logic [5:0] x);
    logic [5:0] r;
    r = x;
    if (r >= 6'd56) r = r - 6'd56;
    if (r >= 6'd28) r = r - 6'd28;
    if (r >= 6'd14) r = r - 6'd14;
    if (r >= 6'd7)  r = r - 6'd7;
    return r[2:0];
  endfunction

  // Number of days in a run of years, evaluated at elaboration
  function automatic int unsigned span_days(int unsigned first, int unsigned span);
    int unsigned total;
    int unsigned y;
    total = 0;
    for (y = first; y < first + span; y++) begin
      total += ((y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0))) ? 366 : 365;
    end
    return total;
  endfunction

endpackage

// ===== src/calendar_date_counter.sv =====
// Top level of the calendar date counter
// A command is taken when start is high and busy is low; its single result appears in the
// cycle after the work ends, for exactly one cycle with done_o high, and cannot be held
// off. Unused opcodes and loads with a bad month or year finish at once (result on the
// next cycle). Every other command walks a year cursor one calendar year per cycle from
// the year the last command left it in to the target year, then walks months from
// January one per cycle until it reaches the target month.
module calendar_date_counter
  import caldc_pkg::*;
#(
  parameter int unsigned START_YEAR = 1900,
  parameter int unsigned YEAR_SPAN  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [3:0]  load_month_i,
  input  logic [4:0]  load_day_i,
  input  logic [11:0] load_year_i,
  input  logic [15:0] day_count_i,
  output logic        done_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [11:0] year_out_o,
  output logic [16:0] day_number_o,
  output logic [2:0]  weekday_o,
  output logic [1:0]  status_o
);

  caldc_cmd_t cmd;
  caldc_sts_t sts;

  caldc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  caldc_dp #(
    .START_YEAR(START_YEAR),
    .YEAR_SPAN (YEAR_SPAN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .opcode_i    (opcode_i),
    .load_month_i(load_month_i),
    .load_day_i  (load_day_i),
    .load_year_i (load_year_i),
    .day_count_i (day_count_i),
    .month_o     (month_out_o),
    .day_o       (day_out_o),
    .year_o      (year_out_o),
    .day_number_o(day_number_o),
    .weekday_o   (weekday_o),
    .status_o    (status_o),
    .done_o      (done_o)
  );

endmodule

// ===== src/caldc_ctrl.sv =====
// Controller state machine of the calendar date counter
`include "calendar_date_counter_defines.svh"

module caldc_ctrl
  import caldc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  caldc_sts_t sts_i,
  output caldc_cmd_t cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && !sts_i.quick) state_d = S_YEAR;
      end
      S_YEAR: begin
        if (sts_i.year_done) state_d = S_MONTH;
      end
      S_MONTH: begin
        if (sts_i.month_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.start  = 1'b1;
          cmd_o.finish = sts_i.quick;
        end
      end
      S_YEAR: begin
        if (sts_i.year_done) cmd_o.month_init = 1'b1;
        else                 cmd_o.year_step  = 1'b1;
      end
      S_MONTH: begin
        if (sts_i.month_done) begin
          cmd_o.commit = 1'b1;
          cmd_o.finish = 1'b1;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `CALDC_ASSERT_NEXT(a_finish_idle, cmd_o.finish, state_q == S_IDLE, "not idle after finish")
  `CALDC_ASSERT_NEXT(a_walk_busy, cmd_o.start && !sts_i.quick, busy_o, "walk not busy")

endmodule

// ===== src/caldc_dp.sv =====
// Datapath of the calendar date counter: year cursor, month walk and date registers
`include "calendar_date_counter_defines.svh"

module caldc_dp
  import caldc_pkg::*;
#(
  parameter int unsigned START_YEAR = 1900,
  parameter int unsigned YEAR_SPAN  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  caldc_cmd_t  cmd_i,
  output caldc_sts_t  sts_o,
  input  logic [2:0]  opcode_i,
  input  logic [3:0]  load_month_i,
  input  logic [4:0]  load_day_i,
  input  logic [11:0] load_year_i,
  input  logic [15:0] day_count_i,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [11:0] year_o,
  output logic [16:0] day_number_o,
  output logic [2:0]  weekday_o,
  output logic [1:0]  status_o,
  output logic        done_o
);

  localparam int unsigned LastNum = span_days(START_YEAR, YEAR_SPAN) - 1;
  localparam int unsigned DnW     = $clog2(LastNum + 2);
  localparam int unsigned YrW     = $clog2(START_YEAR + YEAR_SPAN);
  localparam int unsigned CmpW    = ((DnW > 16) ? DnW : 16) + 1;
  localparam int unsigned LyW     = ((YrW > 12) ? YrW : 12) + 1;
  localparam int unsigned NumW    = (DnW > 17) ? DnW : 17;
  localparam int unsigned YoW     = (YrW > 12) ? YrW : 12;

  // Committed date
  logic [3:0]     month_q;
  logic [4:0]     day_q;
  logic [YrW-1:0] year_q;
  logic [DnW-1:0] dn_q;
  logic [2:0]     wd_q;
  status_e        status_q;
  logic           done_q;

  // Year cursor: a year, the day number of its first day and its calendar position
  logic [YrW-1:0] cy_q;
  logic [DnW-1:0] cstart_q;
  logic [2:0]     cwd_q;
  logic [6:0]     c100_q;
  logic [8:0]     c400_q;

  // Item in flight and month walk
  logic           mode_load_q;
  logic [DnW-1:0] tgt_q;
  logic [3:0]     lm_q;
  logic [4:0]     ld_q;
  logic [YrW-1:0] ly_q;
  logic [3:0]     m_q;
  logic [8:0]     off_q;
  logic [8:0]     rest_q;
  logic [2:0]     mwd_q;

  // Decode the command and work out the target day number
  opcode_e         op;
  logic [CmpW-1:0] cnt_x, n_x, last_x;
  logic [LyW-1:0]  ly_x;
  logic            ly_ok, lm_ok, quick, mode_load;
  status_e         st_start;
  logic [DnW-1:0]  tgt_d;

  always_comb begin
    op        = opcode_e'(opcode_i);
    cnt_x     = ((op == OP_NEXT) || (op == OP_PREV)) ? CmpW'(1) : CmpW'(day_count_i);
    n_x       = CmpW'(dn_q);
    last_x    = CmpW'(LastNum);
    ly_x      = LyW'(load_year_i);
    ly_ok     = (ly_x >= LyW'(START_YEAR)) && (ly_x < LyW'(START_YEAR + YEAR_SPAN));
    lm_ok     = (load_month_i >= 4'd1) && (load_month_i <= MonthLast);
    quick     = 1'b0;
    mode_load = 1'b0;
    st_start  = ST_OK;
    tgt_d     = dn_q;
    unique case (op) inside
      OP_LOAD: begin
        mode_load = 1'b1;
        if (!(lm_ok && ly_ok)) begin
          quick    = 1'b1;
          st_start = ST_BAD_LOAD;
        end
      end
      OP_NEXT, OP_ADD: begin
        if (cnt_x > (last_x - n_x)) begin
          tgt_d    = DnW'(LastNum);
          st_start = ST_CLAMP;
        end else begin
          tgt_d = DnW'(n_x + cnt_x);
        end
      end
      OP_PREV, OP_SUB: begin
        if (cnt_x > n_x) begin
          tgt_d    = '0;
          st_start = ST_CLAMP;
        end else begin
          tgt_d = DnW'(n_x - cnt_x);
        end
      end
      default: quick = 1'b1;
    endcase
  end

  // Cursor neighbors (this year, the one before and the one after) and walk direction
  logic           leap_cur, leap_prev;
  logic [8:0]     ylen_cur, ylen_prev;
  logic [6:0]     n100, p100;
  logic [8:0]     n400, p400;
  logic [1:0]     yprev_lo;
  logic [DnW:0]   cend;
  logic           fwd, year_done;

  always_comb begin
    leap_cur  = is_leap(cy_q[1:0], c100_q, c400_q);
    ylen_cur  = DaysCommon + 9'(leap_cur);
    n100      = (c100_q == 7'd99)  ? 7'd0 : c100_q + 7'd1;
    n400      = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
    p100      = (c100_q == 7'd0)   ? 7'd99 : c100_q - 7'd1;
    p400      = (c400_q == 9'd0)   ? 9'd399 : c400_q - 9'd1;
    yprev_lo  = cy_q[1:0] - 2'd1;
    leap_prev = is_leap(yprev_lo, p100, p400);
    ylen_prev = DaysCommon + 9'(leap_prev);
    cend      = {1'b0, cstart_q} + (DnW + 1)'(ylen_cur);
    if (mode_load_q) begin
      fwd       = (cy_q < ly_q);
      year_done = (cy_q == ly_q);
    end else begin
      fwd       = ({1'b0, tgt_q} >= cend);
      year_done = (tgt_q >= cstart_q) && !fwd;
    end
  end

  // Month walk status and commit values
  logic [4:0] mlen;
  logic       month_done, day_ok;

  always_comb begin
    mlen       = month_len(m_q, leap_cur);
    month_done = mode_load_q ? (m_q == lm_q) : (rest_q < 9'(mlen));
    day_ok     = (ld_q != 5'd0) && (ld_q <= mlen);
  end

  assign sts_o.quick      = quick;
  assign sts_o.year_done  = year_done;
  assign sts_o.month_done = month_done;

  // Capture the item and walk the months
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_load_q <= mode_load;
      tgt_q       <= tgt_d;
      lm_q        <= load_month_i;
      ld_q        <= load_day_i;
      ly_q        <= YrW'(load_year_i);
    end
    if (cmd_i.month_init) begin
      m_q    <= 4'd1;
      off_q  <= 9'd0;
      rest_q <= 9'(tgt_q - cstart_q);
      mwd_q  <= cwd_q;
    end else if (cmd_i.month_step) begin
      m_q    <= m_q + 4'd1;
      off_q  <= off_q + 9'(mlen);
      rest_q <= rest_q - 9'(mlen);
      mwd_q  <= mod7(6'(mwd_q) + 6'(mlen));
    end
  end

  // Advance or back up the year cursor one year at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cy_q     <= YrW'(START_YEAR);
      cstart_q <= '0;
      cwd_q    <= WdayFirst;
      c100_q   <= 7'(START_YEAR % 100);
      c400_q   <= 9'(START_YEAR % 400);
    end else if (cmd_i.year_step) begin
      if (fwd) begin
        cy_q     <= cy_q + YrW'(1);
        cstart_q <= DnW'(cend);
        cwd_q    <= mod7(6'(cwd_q) + (leap_cur ? 6'd2 : 6'd1));
        c100_q   <= n100;
        c400_q   <= n400;
      end else begin
        cy_q     <= cy_q - YrW'(1);
        cstart_q <= cstart_q - DnW'(ylen_prev);
        cwd_q    <= mod7(6'(cwd_q) + 6'd7 - (leap_prev ? 6'd2 : 6'd1));
        c100_q   <= p100;
        c400_q   <= p400;
      end
    end
  end

  // Commit the new date and flag the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q  <= 4'd1;
      day_q    <= 5'd1;
      year_q   <= YrW'(START_YEAR);
      dn_q     <= '0;
      wd_q     <= WdayFirst;
      status_q <= ST_OK;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.start) begin
        status_q <= st_start;
      end
      if (cmd_i.commit) begin
        if (!mode_load_q) begin
          month_q <= m_q;
          day_q   <= 5'(rest_q) + 5'd1;
          year_q  <= cy_q;
          dn_q    <= tgt_q;
          wd_q    <= mod7(6'(mwd_q) + 6'(rest_q));
        end else if (day_ok) begin
          month_q <= m_q;
          day_q   <= ld_q;
          year_q  <= cy_q;
          dn_q    <= cstart_q + DnW'(off_q) + DnW'(ld_q) - DnW'(1);
          wd_q    <= mod7(6'(mwd_q) + 6'(ld_q) - 6'd1);
        end else begin
          status_q <= ST_BAD_LOAD;
        end
      end
    end
  end

  // Drive the result ports
  logic [NumW-1:0] dn_ext;
  logic [YoW-1:0]  yr_ext;

  assign dn_ext       = NumW'(dn_q);
  assign yr_ext       = YoW'(year_q);
  assign month_o      = month_q;
  assign day_o        = day_q;
  assign year_o       = yr_ext[11:0];
  assign day_number_o = dn_ext[16:0];
  assign weekday_o    = wd_q;
  assign status_o     = status_q;
  assign done_o       = done_q;

  `CALDC_ASSERT(a_wday_range, (wd_q < 3'd7) && (cwd_q < 3'd7), "weekday out of range")
  `CALDC_ASSERT(a_dn_range, dn_q <= DnW'(LastNum), "day number beyond last day")
  `CALDC_ASSERT_NEXT(a_commit_num, cmd_i.commit && !mode_load_q, dn_q == $past(tgt_q), "bad commit")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the calendar date counter: random and directed commands
module tb_top
  import caldc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FirstYear   = 1900;
  localparam int unsigned YearSpan    = 256;
  localparam int unsigned LastYear    = FirstYear + YearSpan - 1;
  localparam int unsigned MonthsYear  = 12;
  localparam int unsigned DaysPerWeek = 7;
  localparam int          ClkPeriod   = 10;
  localparam int          ResetCycles = 8;
  localparam int          MaxGap      = 17;
  localparam int          RandItems   = 1725;
  localparam int          TailCycles  = 300;
  localparam int          MaxReported = 10;
  localparam int          LimitCycles = 2_500_000;

  // Opcodes the block leaves unused
  localparam logic [2:0] OpSpareFirst = 3'd5;
  localparam logic [2:0] OpSpareLast  = 3'd7;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [11:0] year;
    logic [15:0] count;
    logic [4:0]  gap;
  } date_cmd_t;

  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [11:0] year;
    logic [16:0] number;
    logic [2:0]  wday;
    logic [1:0]  status;
  } date_result_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic [2:0]  opcode_i     = '0;
  logic [3:0]  load_month_i = '0;
  logic [4:0]  load_day_i   = '0;
  logic [11:0] load_year_i  = '0;
  logic [15:0] day_count_i  = '0;
  logic        done_o;
  logic [3:0]  month_out_o;
  logic [4:0]  day_out_o;
  logic [11:0] year_out_o;
  logic [16:0] day_number_o;
  logic [2:0]  weekday_o;
  logic [1:0]  status_o;

  date_cmd_t    pending_q[$];
  date_result_t expected_dates_q[$];
  logic         item_taken  = 1'b0;
  int           idle_cycles = 0;
  int           no_gap_left = 0;
  int           error_cnt   = 0;

  // Run statistics
  int cmds_taken = 0, loads_taken = 0, loads_rejected = 0, steps_taken = 0;
  int arith_taken = 0, spare_taken = 0, clamps_seen = 0, results_seen = 0;

  // Predicted calendar state
  int unsigned cal_month, cal_day, cal_year, cal_ordinal;

  calendar_date_counter #(
    .START_YEAR(FirstYear),
    .YEAR_SPAN (YearSpan)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .load_month_i(load_month_i),
    .load_day_i  (load_day_i),
    .load_year_i (load_year_i),
    .day_count_i (day_count_i),
    .done_o      (done_o),
    .month_out_o (month_out_o),
    .day_out_o   (day_out_o),
    .year_out_o  (year_out_o),
    .day_number_o(day_number_o),
    .weekday_o   (weekday_o),
    .status_o    (status_o)
  );

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_year(int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  // Zero for a month number that means nothing
  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // Days from 1 January of the first year to a valid date
  function automatic int unsigned ordinal_of(int unsigned m, int unsigned d, int unsigned y);
    int unsigned n;
    n = 0;
    for (int unsigned i = FirstYear; i < y; i++) n += days_in_year(i);
    for (int unsigned i = 1; i < m; i++) n += days_in_month(i, y);
    return n + d - 1;
  endfunction

  // Rebuild the calendar state from an in-range day index
  task automatic set_calendar(input int unsigned n);
    int unsigned y, m, rest;
    y    = FirstYear;
    m    = 1;
    rest = n;
    while (rest >= days_in_year(y)) begin
      rest -= days_in_year(y);
      y++;
    end
    while (rest >= days_in_month(m, y)) begin
      rest -= days_in_month(m, y);
      m++;
    end
    cal_year    = y;
    cal_month   = m;
    cal_day     = rest + 1;
    cal_ordinal = n;
  endtask

  // Apply one command to the calendar state and form its result
  task automatic predict_command(input date_cmd_t c, output date_result_t r);
    int unsigned last_idx, n, cnt;
    status_e     st;
    last_idx = ordinal_of(MonthsYear, days_in_month(MonthsYear, LastYear), LastYear);
    n        = cal_ordinal;
    cnt      = c.count;
    st       = ST_OK;
    case (c.opcode)
      OP_LOAD: begin
        if (c.month >= 1 && c.month <= MonthsYear && c.year >= FirstYear &&
            c.year <= LastYear && c.day >= 1 && c.day <= days_in_month(c.month, c.year))
          set_calendar(ordinal_of(c.month, c.day, c.year));
        else
          st = ST_BAD_LOAD;
      end
      OP_NEXT, OP_ADD: begin
        if (c.opcode == OP_NEXT) cnt = 1;
        if (cnt > last_idx - n) begin
          n  = last_idx;
          st = ST_CLAMP;
        end else begin
          n += cnt;
        end
        set_calendar(n);
      end
      OP_PREV, OP_SUB: begin
        if (c.opcode == OP_PREV) cnt = 1;
        if (cnt > n) begin
          n  = 0;
          st = ST_CLAMP;
        end else begin
          n -= cnt;
        end
        set_calendar(n);
      end
      default: ;
    endcase
    r.month  = 4'(cal_month);
    r.day    = 5'(cal_day);
    r.year   = 12'(cal_year);
    r.number = 17'(cal_ordinal);
    r.wday   = 3'((cal_ordinal + 1) % DaysPerWeek);
    r.status = st;
  endtask

  task automatic report_error(input string msg);
    error_cnt++;
    if (error_cnt <= MaxReported) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Queue one command with its lead-in gap
  task automatic add_cmd(input logic [2:0] op, input int unsigned m, input int unsigned d,
                         input int unsigned y, input int unsigned cnt);
    date_cmd_t c;
    c.opcode = op;
    c.month  = 4'(m);
    c.day    = 5'(d);
    c.year   = 12'(y);
    c.count  = 16'(cnt);
    if (no_gap_left > 0) begin
      c.gap = '0;
      no_gap_left--;
    end else begin
      c.gap = 5'($urandom_range(0, MaxGap));
    end
    pending_q.push_back(c);
  endtask

  // Clock
  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Drive commands at the falling edge; hold start until the item is taken
  always @(negedge clk_i) begin : driver
    logic      start_nx;
    date_cmd_t nxt;
    start_nx = start;
    if (rst_ni) begin
      if (start && item_taken) begin
        start_nx    = 1'b0;
        idle_cycles = 0;
      end else if (!start) begin
        idle_cycles++;
      end
      if (!start_nx && pending_q.size() != 0 && idle_cycles >= pending_q[0].gap) begin
        nxt          = pending_q.pop_front();
        opcode_i     <= nxt.opcode;
        load_month_i <= nxt.month;
        load_day_i   <= nxt.day;
        load_year_i  <= nxt.year;
        day_count_i  <= nxt.count;
        start_nx     = 1'b1;
      end
    end
    start <= start_nx;
  end

  // Check results and predict accepted items at the rising edge
  always @(posedge clk_i) begin : monitor
    date_result_t got, want;
    date_cmd_t    cmd;
    if (!rst_ni) begin
      item_taken <= 1'b0;
    end else begin
      if (done_o) begin
        got.month  = month_out_o;
        got.day    = day_out_o;
        got.year   = year_out_o;
        got.number = day_number_o;
        got.wday   = weekday_o;
        got.status = status_o;
        results_seen++;
        if (expected_dates_q.size() == 0) begin
          report_error($sformatf("result %0d/%0d/%0d with no command waiting",
                                 got.month, got.day, got.year));
        end else begin
          want = expected_dates_q.pop_front();
          if (got.month !== want.month || got.day !== want.day || got.year !== want.year ||
              got.number !== want.number || got.wday !== want.wday ||
              got.status !== want.status)
            report_error($sformatf(
              "result %0d: got %0d/%0d/%0d n=%0d wd=%0d st=%0d, exp %0d/%0d/%0d n=%0d wd=%0d st=%0d",
              results_seen, got.month, got.day, got.year, got.number, got.wday, got.status,
              want.month, want.day, want.year, want.number, want.wday, want.status));
        end
      end
      item_taken <= start && !busy;
      if (start && !busy) begin
        cmd.opcode = opcode_i;
        cmd.month  = load_month_i;
        cmd.day    = load_day_i;
        cmd.year   = load_year_i;
        cmd.count  = day_count_i;
        cmd.gap    = '0;
        predict_command(cmd, want);
        expected_dates_q.push_back(want);
        cmds_taken++;
        if (want.status == ST_CLAMP) clamps_seen++;
        case (cmd.opcode)
          OP_LOAD: begin
            loads_taken++;
            if (want.status == ST_BAD_LOAD) loads_rejected++;
          end
          OP_NEXT, OP_PREV: steps_taken++;
          OP_ADD, OP_SUB:   arith_taken++;
          default:          spare_taken++;
        endcase
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int unsigned pick, m, d, y, cnt;
    set_calendar(0);

    // Directed: range limits, leap rules, bad loads, spare opcodes
    add_cmd(OP_PREV, 0, 0, 0, 0);
    add_cmd(OP_SUB, 0, 0, 0, 0);
    add_cmd(OP_ADD, 0, 0, 0, 0);
    add_cmd(OP_SUB, 0, 0, 0, 16'hFFFF);
    add_cmd(OP_ADD, 0, 0, 0, 16'hFFFF);
    add_cmd(OP_ADD, 0, 0, 0, 16'hFFFF);
    add_cmd(OP_NEXT, 0, 0, 0, 0);
    add_cmd(OP_PREV, 0, 0, 0, 0);
    add_cmd(OP_LOAD, 12, 31, LastYear, 0);
    add_cmd(OP_NEXT, 0, 0, 0, 0);
    add_cmd(OP_LOAD, 2, 29, 2000, 0);
    add_cmd(OP_LOAD, 2, 29, 1900, 0);
    add_cmd(OP_LOAD, 2, 29, 2100, 0);
    add_cmd(OP_LOAD, 2, 29, 2004, 0);
    add_cmd(OP_LOAD, 4, 31, 2020, 0);
    add_cmd(OP_LOAD, 0, 10, 2020, 0);
    add_cmd(OP_LOAD, 13, 1, 2020, 0);
    add_cmd(OP_LOAD, 15, 31, 4095, 0);
    add_cmd(OP_LOAD, 1, 0, 2020, 0);
    add_cmd(OP_LOAD, 1, 1, FirstYear - 1, 0);
    add_cmd(OP_LOAD, 1, 1, LastYear + 1, 0);
    add_cmd(OP_LOAD, 12, 31, 1999, 0);
    add_cmd(OP_NEXT, 0, 0, 0, 0);
    add_cmd(OP_PREV, 0, 0, 0, 0);
    for (int op = OpSpareFirst; op <= OpSpareLast; op++) add_cmd(3'(op), 0, 0, 0, 0);

    // Random: mostly valid dates and moves, some junk loads and spare opcodes
    for (int i = 0; i < RandItems; i++) begin
      if (i % 150 == 0) no_gap_left = 25;
      pick = $urandom_range(0, 99);
      m    = $urandom_range(0, 15);
      d    = $urandom_range(0, 31);
      y    = $urandom_range(0, 4095);
      cnt  = $urandom_range(0, 65535);
      if (pick < 22) begin
        y = $urandom_range(FirstYear, LastYear);
        m = $urandom_range(1, MonthsYear);
        d = $urandom_range(1, days_in_month(m, y));
        add_cmd(OP_LOAD, m, d, y, cnt);
      end else if (pick < 30) begin
        // Land on first or last days of January, February or December in limit, century and leap years
        case ($urandom_range(0, 4))
          0:       y = FirstYear;
          1:       y = LastYear;
          2:       y = 2000;
          3:       y = 2100;
          default: y = 1904;
        endcase
        case ($urandom_range(0, 2))
          0:       m = 1;
          1:       m = 2;
          default: m = MonthsYear;
        endcase
        d = $urandom_range(0, 1) ? 1 : days_in_month(m, y);
        add_cmd(OP_LOAD, m, d, y, cnt);
      end else if (pick < 37) begin
        if ($urandom_range(0, 1)) begin
          y = $urandom_range(FirstYear, LastYear);
          m = $urandom_range(1, MonthsYear);
          d = days_in_month(m, y) + 1;
        end
        add_cmd(OP_LOAD, m, d, y, cnt);
      end else if (pick < 52) begin
        add_cmd(OP_NEXT, m, d, y, cnt);
      end else if (pick < 67) begin
        add_cmd(OP_PREV, m, d, y, cnt);
      end else if (pick < 95) begin
        case ($urandom_range(0, 3))
          0:       cnt = $urandom_range(0, 40);
          1:       cnt = $urandom_range(0, 1000);
          2:       cnt = $urandom_range(0, 8000);
          default: ;
        endcase
        add_cmd(pick < 81 ? OP_ADD : OP_SUB, m, d, y, cnt);
      end else begin
        add_cmd(3'($urandom_range(OpSpareFirst, OpSpareLast)), m, d, y, cnt);
      end
    end

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all items sent, all results back, then a quiet tail
    while (pending_q.size() != 0 || start) @(negedge clk_i);
    while (expected_dates_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (expected_dates_q.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_dates_q.size()));

    $display("Covered %0d commands: %0d loads (%0d rejected), %0d day steps, %0d add/sub, %0d spare",
             cmds_taken, loads_taken, loads_rejected, steps_taken, arith_taken, spare_taken);
    $display("Checked %0d results, %0d clamped at range limits, %0d errors",
             results_seen, clamps_seen, error_cnt);
    if (error_cnt == 0) begin
      $display("PASS calendar_date_counter");
    end else begin
      $display("FAIL calendar_date_counter");
    end
    $finish;
  end

  // Timeout
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("FAIL calendar_date_counter");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/caldc_pkg.sv
src/caldc_ctrl.sv
src/caldc_dp.sv
src/calendar_date_counter.sv
verif/tb_top.sv
